/* rtl/bmts_pkg.sv */
// bmts_pkg: types, codes and reset constants for the buzzer tone sequencer
// no dependencies; imported by beep_and_melody_tone_sequencer
`default_nettype none

package bmts_pkg;

  // request kinds on the input channel
  typedef enum logic [2:0] {
    MODE_TICK      = 3'd0,
    MODE_START_BEEP = 3'd1,
    MODE_START_MEL = 3'd2,
    MODE_STOP      = 3'd3,
    MODE_LOAD      = 3'd4
  } mode_t;

  // sequencer play mode
  typedef enum logic [1:0] {
    PM_IDLE   = 2'd0,
    PM_BEEP   = 2'd1,
    PM_MELODY = 2'd2
  } play_kind_t;

  // configuration register indexes
  localparam logic [2:0] REG_SOUND_EN   = 3'd0;
  localparam logic [2:0] REG_BEEP_PITCH = 3'd1;
  localparam logic [2:0] REG_BEEP_ON    = 3'd2;
  localparam logic [2:0] REG_BEEP_OFF   = 3'd3;
  localparam logic [2:0] REG_DUTY       = 3'd4;
  localparam logic [2:0] REG_MIN_PITCH  = 3'd5;
  localparam logic [2:0] REG_DEF_TICKS  = 3'd6;

  // reset values
  localparam int unsigned NOTE_DEPTH_DEF      = 64;
  localparam logic [15:0] BEEP_PITCH_RST      = 16'd3000;
  localparam logic [15:0] BEEP_ON_RST         = 16'd60;
  localparam logic [15:0] BEEP_OFF_RST        = 16'd60;
  localparam logic [9:0]  DUTY_RST            = 10'd512;
  localparam logic [15:0] MIN_PITCH_RST       = 16'd100;
  localparam logic [15:0] DEF_TICKS_RST       = 16'd50;
  localparam logic [15:0] PITCH_RST           = 16'd3000;

  // raise a frequency to the minimum allowed
  function automatic logic [15:0] clamp_pitch(input logic [15:0] hz,
                                              input logic [15:0] min_hz);
    clamp_pitch = (hz < min_hz) ? min_hz : hz;
  endfunction

endpackage

`default_nettype wire

/* rtl/beep_and_melody_tone_sequencer.sv */
// beep_and_melody_tone_sequencer: buzzer beep and melody sequencer, top level
// depends on bmts_pkg; holds the note store memory
`default_nettype none

// Usage:
// in channel (in_tvalid/in_tready/in_tuser/in_tdata) carries one request per
// item: a 1 ms tick, start beeps, start melody, stop or load note (in_tuser).
// out channel returns exactly one tone state item per accepted request:
// tone on, pitch, duty and play state after that request took effect.
// cfg_we/cfg_index/cfg_wdata write the seven setup registers; write them only
// while no request is in flight.
// The result is registered: the result of a request accepted at one edge is on
// out_tdata after that edge. One request per cycle is sustained while out_tready
// is high; the single result register frees as it is taken, so in_tready only
// drops when that register is full and out_tready is low.
// The note store is a single-write memory with registered reads: one port
// prefetches the note at the next melody position, the other holds slot 0 for
// a melody start; a load to the slot being fetched is forwarded.
// Reset (rst_n low, synchronous) returns to idle with no timer armed, pitch
// 3000 Hz and register defaults; note store contents stay undefined until
// loaded. While the receiver stalls, the result is held and no request taken.
module beep_and_melody_tone_sequencer
  import bmts_pkg::*;
#(
  parameter int unsigned NOTE_DEPTH = NOTE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [2:0]  in_tuser,   // mode
  input  wire logic [47:0] in_tdata,   // override, count, slot, pitch, note_ticks
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // tone_on, pitch_out, duty_out, play_state
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  localparam int unsigned AW = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;
  localparam int unsigned PW = $clog2(NOTE_DEPTH + 1);

  // configuration registers
  logic        sound_en_r;
  logic [15:0] beep_pitch_r, beep_on_r, beep_off_r, min_pitch_r, def_ticks_r;
  logic [9:0]  duty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sound_en_r   <= 1'b1;
      beep_pitch_r <= BEEP_PITCH_RST;
      beep_on_r    <= BEEP_ON_RST;
      beep_off_r   <= BEEP_OFF_RST;
      duty_r       <= DUTY_RST;
      min_pitch_r  <= MIN_PITCH_RST;
      def_ticks_r  <= DEF_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SOUND_EN:   sound_en_r   <= cfg_wdata[0];
        REG_BEEP_PITCH: beep_pitch_r <= cfg_wdata;
        REG_BEEP_ON:    beep_on_r    <= cfg_wdata;
        REG_BEEP_OFF:   beep_off_r   <= cfg_wdata;
        REG_DUTY:       duty_r       <= cfg_wdata[9:0];
        REG_MIN_PITCH:  min_pitch_r  <= cfg_wdata;
        REG_DEF_TICKS:  def_ticks_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // request fields
  mode_t       in_mode;
  logic        in_override;
  logic [7:0]  in_count;
  logic [5:0]  in_slot;
  logic [15:0] in_pitch, in_note_ticks;

  assign in_mode       = mode_t'(in_tuser);
  assign in_override   = in_tdata[0];
  assign in_count      = in_tdata[8:1];
  assign in_slot       = in_tdata[14:9];
  assign in_pitch      = in_tdata[30:15];
  assign in_note_ticks = in_tdata[46:31];

  // sequencer state
  play_kind_t  play_mode_r, play_mode_nxt;
  logic        tone_r, tone_nxt;
  logic [7:0]  beeps_left_r, beeps_left_nxt;
  logic [PW-1:0] note_pos_r, note_pos_nxt, note_total_r, note_total_nxt;
  logic [15:0] ticks_left_r, ticks_left_nxt;
  logic [15:0] pitch_r, pitch_nxt;

  // result register
  logic        out_valid_r;
  logic [31:0] out_data_r;

  logic accept;
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // note store with forwarding of a load to the prefetched slots
  logic [31:0]   note_mem [NOTE_DEPTH];
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [31:0]   wr_data;
  logic [31:0]   note_rd_r, note0_rd_r, byp_data_r;
  logic          byp_cur_r, byp0_r;
  logic [31:0]   note_cur, note0;

  assign wr_en   = accept && (in_mode == MODE_LOAD) && (32'(in_slot) < NOTE_DEPTH);
  assign wr_addr = AW'(in_slot);
  assign wr_data = {in_note_ticks, in_pitch};
  assign rd_addr = AW'(note_pos_nxt);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      note_mem[wr_addr] <= wr_data;
    end
    note_rd_r  <= note_mem[rd_addr];
    note0_rd_r <= note_mem[0];
    byp_data_r <= wr_data;
    byp_cur_r  <= wr_en && (wr_addr == rd_addr);
    byp0_r     <= wr_en && (wr_addr == '0);
  end

  assign note_cur = byp_cur_r ? byp_data_r : note_rd_r;
  assign note0    = byp0_r ? byp_data_r : note0_rd_r;

  // next state for one request
  always_comb begin
    logic          allowed, start_mel;
    logic [31:0]   adv_entry;
    logic [PW-1:0] adv_pos, adv_total, sat_count;
    logic [15:0]   tick_dec;

    allowed   = (in_count != 8'd0) && (in_override || sound_en_r);
    start_mel = (in_mode == MODE_START_MEL);
    sat_count = (32'(in_count) > NOTE_DEPTH) ? PW'(NOTE_DEPTH) : PW'(in_count);
    adv_entry = start_mel ? note0 : note_cur;
    adv_pos   = start_mel ? '0 : note_pos_r;
    adv_total = start_mel ? sat_count : note_total_r;
    tick_dec  = ticks_left_r - 16'd1;

    play_mode_nxt  = play_mode_r;
    tone_nxt       = tone_r;
    beeps_left_nxt = beeps_left_r;
    note_pos_nxt   = note_pos_r;
    note_total_nxt = note_total_r;
    ticks_left_nxt = ticks_left_r;
    pitch_nxt      = pitch_r;

    if (accept) begin
      case (in_mode)
        MODE_TICK: begin
          if (ticks_left_r != 16'd0) begin
            ticks_left_nxt = tick_dec;
            if (tick_dec == 16'd0) begin
              if (play_mode_r == PM_MELODY) begin
                if (adv_pos >= adv_total) begin
                  play_mode_nxt  = PM_IDLE;
                  tone_nxt       = 1'b0;
                  beeps_left_nxt = '0;
                  note_pos_nxt   = '0;
                  note_total_nxt = '0;
                  ticks_left_nxt = '0;
                end else begin
                  note_pos_nxt = PW'(adv_pos + 1'b1);
                  tone_nxt     = (adv_entry[15:0] != 16'd0);
                  if (adv_entry[15:0] != 16'd0) begin
                    pitch_nxt = clamp_pitch(adv_entry[15:0], min_pitch_r);
                  end
                  ticks_left_nxt = (adv_entry[31:16] != 16'd0) ? adv_entry[31:16]
                                                               : def_ticks_r;
                end
              end else if (play_mode_r == PM_BEEP) begin
                if (tone_r) begin
                  tone_nxt = 1'b0;
                  if (beeps_left_r != 8'd0) begin
                    ticks_left_nxt = beep_off_r;
                  end else begin
                    play_mode_nxt = PM_IDLE;
                  end
                end else begin
                  pitch_nxt = clamp_pitch(beep_pitch_r, min_pitch_r);
                  tone_nxt  = 1'b1;
                  if (beeps_left_r != 8'd0) begin
                    beeps_left_nxt = beeps_left_r - 8'd1;
                  end
                  ticks_left_nxt = beep_on_r;
                end
              end
            end
          end
        end
        MODE_START_BEEP: begin
          if (allowed) begin
            play_mode_nxt  = PM_BEEP;
            beeps_left_nxt = in_count - 8'd1;
            note_pos_nxt   = '0;
            note_total_nxt = '0;
            tone_nxt       = 1'b1;
            pitch_nxt      = clamp_pitch(beep_pitch_r, min_pitch_r);
            ticks_left_nxt = beep_on_r;
          end
        end
        MODE_START_MEL: begin
          if (allowed) begin
            beeps_left_nxt = '0;
            if (adv_pos >= adv_total) begin
              play_mode_nxt  = PM_IDLE;
              tone_nxt       = 1'b0;
              note_pos_nxt   = '0;
              note_total_nxt = '0;
              ticks_left_nxt = '0;
            end else begin
              play_mode_nxt  = PM_MELODY;
              note_total_nxt = adv_total;
              note_pos_nxt   = PW'(adv_pos + 1'b1);
              tone_nxt       = (adv_entry[15:0] != 16'd0);
              if (adv_entry[15:0] != 16'd0) begin
                pitch_nxt = clamp_pitch(adv_entry[15:0], min_pitch_r);
              end
              ticks_left_nxt = (adv_entry[31:16] != 16'd0) ? adv_entry[31:16]
                                                           : def_ticks_r;
            end
          end
        end
        MODE_STOP: begin
          play_mode_nxt  = PM_IDLE;
          tone_nxt       = 1'b0;
          beeps_left_nxt = '0;
          note_pos_nxt   = '0;
          note_total_nxt = '0;
          ticks_left_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      play_mode_r  <= PM_IDLE;
      tone_r       <= 1'b0;
      beeps_left_r <= '0;
      note_pos_r   <= '0;
      note_total_r <= '0;
      ticks_left_r <= '0;
      pitch_r      <= PITCH_RST;
    end else begin
      play_mode_r  <= play_mode_nxt;
      tone_r       <= tone_nxt;
      beeps_left_r <= beeps_left_nxt;
      note_pos_r   <= note_pos_nxt;
      note_total_r <= note_total_nxt;
      ticks_left_r <= ticks_left_nxt;
      pitch_r      <= pitch_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= {3'b000, play_mode_nxt, (tone_nxt ? duty_r : 10'd0),
                     pitch_nxt, tone_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
